[rtl/ddbs_pkg.sv]
`timescale 1ns / 1ps

package ddbs_pkg;

  localparam int StatusWidth = 8;
  localparam int ActionWidth = 4;
  localparam int RetryWidth = 9;
  localparam int RevisionWidth = 16;

  localparam logic [RetryWidth-1:0] NO_DISC_RETRIES = 9'd26;
  localparam logic [RetryWidth-1:0] NOT_READY_RETRIES = 9'd413;
  localparam logic [RetryWidth-1:0] RETRY_MAX = 9'd511;
  localparam logic [RevisionWidth-1:0] NEW_REVISION_FLOOR = 16'h306b;

  localparam int StReadyBit = 0;
  localparam int StDoubleBit = 1;
  localparam int StSpinBit = 5;
  localparam int StDiscBit = 6;
  localparam int StDoorBit = 7;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_POLL  = 2'd1,
    PH_SPEED = 2'd2,
    PH_EJECT = 2'd3
  } phase_t;

  typedef enum logic [ActionWidth-1:0] {
    ACT_POLL       = 4'd0,
    ACT_DELAY_POLL = 4'd1,
    ACT_SPINUP     = 4'd2,
    ACT_QUERY      = 4'd3,
    ACT_EJECT      = 4'd4,
    ACT_WAIT_POLL  = 4'd5,
    ACT_DOOR_OPEN  = 4'd6,
    ACT_NO_DISC    = 4'd7,
    ACT_EJECTED    = 4'd8,
    ACT_RESET      = 4'd9,
    ACT_READY      = 4'd10
  } action_t;

endpackage

[rtl/disc_drive_bringup_sequencer.sv]
`timescale 1ns / 1ps
// Channel       Direction  Payload
// s_axis        in         tuser: func; tdata: status[7:0]
// m_axis        out        tdata: action[3:0], double_speed[4], zero[7:5]; tlast: finished
// drive_revision in        write enable and 16-bit write data, no read-back
//
// An item is registered on entry and then decided into the result register, which offers it on m_axis,
// and one item is accepted every cycle while m_axis does not stall.
// The phase, retry count and unreadable flag update as each item leaves the input register.
// Reset is synchronous and clears the phase, the retry count, the revision and both valids.
// A stall on m_axis holds the result and, through the input register, backs up s_axis.

module disc_drive_bringup_sequencer
  import ddbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [StatusWidth-1:0]   s_axis_tdata,   // status[7:0]
  input  logic                     s_axis_tuser,   // func
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // action[3:0], double_speed[4], zero[7:5]
  output logic                     m_axis_tlast,
  input  logic                     drive_revision_wr_en,
  input  logic [RevisionWidth-1:0] drive_revision_wr_data
);

  logic [RevisionWidth-1:0] drive_revision;
  logic                     in_valid;
  logic                     in_func;
  logic [StatusWidth-1:0]   in_status;
  logic                     advance;

  phase_t                   phase, phase_next;
  logic [RetryWidth-1:0]    retry_count, retry_count_next;
  logic                     unreadable_seen, unreadable_seen_next;

  action_t                  action_next;
  logic                     finished_next;
  logic                     double_next;

  action_t                  out_action;
  logic                     out_finished;
  logic                     out_double;

  logic newer;
  logic door_closed, disc_in, ready_bit, spinning;
  logic retry_inc;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  assign newer = drive_revision > NEW_REVISION_FLOOR;
  assign door_closed = in_status[StDoorBit];
  assign disc_in = in_status[StDiscBit];
  assign ready_bit = in_status[StReadyBit];
  assign spinning = in_status[StSpinBit];

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_revision <= '0;
    end else if (drive_revision_wr_en) begin
      drive_revision <= drive_revision_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_status <= s_axis_tdata;
    end
  end

  // Next state of the sequencer for the item in the input register.
  always_comb begin
    phase_next = phase;
    retry_count_next = retry_count;
    unreadable_seen_next = unreadable_seen;
    retry_inc = 1'b0;
    if (in_func == FUNC_BEGIN) begin
      phase_next = PH_POLL;
      retry_count_next = '0;
      unreadable_seen_next = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_SPEED: begin
          phase_next = PH_IDLE;
        end
        PH_EJECT: begin
          if (!door_closed) begin
            phase_next = PH_IDLE;
          end
        end
        PH_POLL: begin
          if (!door_closed) begin
            phase_next = PH_IDLE;
          end else if (!disc_in) begin
            if (newer ? !ready_bit : (retry_count < NO_DISC_RETRIES)) begin
              retry_inc = 1'b1;
            end else begin
              phase_next = PH_IDLE;
            end
          end else if (!ready_bit) begin
            if (!newer) begin
              if (retry_count > NOT_READY_RETRIES) begin
                phase_next = PH_IDLE;
              end else begin
                retry_inc = 1'b1;
              end
            end else if (!unreadable_seen) begin
              unreadable_seen_next = 1'b1;
              retry_inc = 1'b1;
            end else begin
              phase_next = PH_EJECT;
            end
          end else if (!spinning) begin
            retry_inc = 1'b1;
          end else begin
            phase_next = PH_SPEED;
          end
        end
        default: begin
        end
      endcase
      if (retry_inc && retry_count != RETRY_MAX) begin
        retry_count_next = retry_count + 1'b1;
      end
    end
  end

  // Result fields for the item in the input register.
  always_comb begin
    action_next = ACT_POLL;
    finished_next = 1'b0;
    double_next = 1'b0;
    if (in_func == FUNC_REPORT) begin
      unique case (phase)
        PH_IDLE: begin
          finished_next = 1'b1;
        end
        PH_SPEED: begin
          action_next = ACT_READY;
          finished_next = 1'b1;
          double_next = in_status[StDoubleBit];
        end
        PH_EJECT: begin
          if (!door_closed) begin
            action_next = ACT_EJECTED;
            finished_next = 1'b1;
          end else begin
            action_next = ACT_WAIT_POLL;
          end
        end
        PH_POLL: begin
          if (!door_closed) begin
            action_next = ACT_DOOR_OPEN;
            finished_next = 1'b1;
          end else if (!disc_in) begin
            if (newer ? !ready_bit : (retry_count < NO_DISC_RETRIES)) begin
              action_next = ACT_DELAY_POLL;
            end else begin
              action_next = ACT_NO_DISC;
              finished_next = 1'b1;
            end
          end else if (!ready_bit) begin
            if (!newer) begin
              if (retry_count > NOT_READY_RETRIES) begin
                action_next = ACT_RESET;
                finished_next = 1'b1;
              end else begin
                action_next = ACT_DELAY_POLL;
              end
            end else if (!unreadable_seen) begin
              action_next = ACT_DELAY_POLL;
            end else begin
              action_next = ACT_EJECT;
            end
          end else if (!spinning) begin
            action_next = ACT_SPINUP;
          end else begin
            action_next = ACT_QUERY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      retry_count <= '0;
      unreadable_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
      if (in_valid) begin
        phase <= phase_next;
        retry_count <= retry_count_next;
        unreadable_seen <= unreadable_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_action <= action_next;
      out_finished <= finished_next;
      out_double <= double_next;
    end
  end

  assign m_axis_tdata = {3'b000, out_double, out_action};
  assign m_axis_tlast = out_finished;

endmodule

[rtl/ddbs_checker.sv]
`timescale 1ns / 1ps

module ddbs_checker
  import ddbs_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [7:0]               m_axis_tdata,
  input logic                     m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled result changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[3:0] >= ACT_DOOR_OPEN) |-> m_axis_tlast)
    else $error("Ending action without finished.");

  a_double_only_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == ACT_READY)
    else $error("Double speed outside the ready result.");

  a_legal_action: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= ACT_READY) && (m_axis_tdata[7:5] == 3'b000))
    else $error("Result code or padding out of range.");

endmodule

bind disc_drive_bringup_sequencer ddbs_checker u_ddbs_checker (.*);

[test/tb_disc_drive_bringup_sequencer.sv]
`timescale 1ns / 1ps

module tb_disc_drive_bringup_sequencer;
  import ddbs_pkg::*;

  localparam int RandomItems = 700;
  localparam int WatchdogLimit = 4000;
  localparam int LongHoldCycles = 300;
  localparam int LongRunAt = 12;
  localparam int NumDirected = 27;

  typedef struct packed {
    action_t act;
    logic    fin;
    logic    dbl;
  } result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               func;
    logic [7:0]         status;
    logic [15:0]        rev;
    logic               typed;
    action_t            act;
    logic               fin;
    logic               dbl;
  } step_row_t;

  localparam step_row_t DirectedSteps [0:NumDirected-1] = '{
    '{ROW_ITEM, FUNC_REPORT, 8'hFF, 16'h0000, 1'b1, ACT_POLL,       1'b1, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'hFF, 16'h0000, 1'b1, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h00, 16'h0000, 1'b1, ACT_DOOR_OPEN,  1'b1, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'h00, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h80, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hC0, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hC1, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hE1, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h02, 16'h0000, 1'b1, ACT_READY,      1'b1, 1'b1},
    '{ROW_ITEM, FUNC_REPORT, 8'h7F, 16'h0000, 1'b1, ACT_POLL,       1'b1, 1'b0},
    '{ROW_CFG,  FUNC_BEGIN,  8'h00, 16'h306C, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'hAA, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h80, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hC0, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hC0, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h80, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h7F, 16'h0000, 1'b1, ACT_EJECTED,    1'b1, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'h00, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h81, 16'h0000, 1'b1, ACT_NO_DISC,    1'b1, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'h00, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hC0, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'hFF, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hDE, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_CFG,  FUNC_BEGIN,  8'h00, 16'h306B, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_BEGIN,  8'h00, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'hFF, 16'h0000, 1'b0, ACT_POLL,       1'b0, 1'b0},
    '{ROW_ITEM, FUNC_REPORT, 8'h00, 16'h0000, 1'b1, ACT_READY,      1'b1, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [StatusWidth-1:0]   s_axis_tdata = '0;   // status[7:0]
  logic                     s_axis_tuser = 1'b0; // func
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;        // action[3:0], double_speed[4], zero[7:5]
  logic                     m_axis_tlast;
  logic                     drive_revision_wr_en = 1'b0;
  logic [RevisionWidth-1:0] drive_revision_wr_data = '0;

  disc_drive_bringup_sequencer i_dut (
    .clk                    (clk),
    .rst                    (rst),
    .s_axis_tvalid          (s_axis_tvalid),
    .s_axis_tready          (s_axis_tready),
    .s_axis_tdata           (s_axis_tdata),
    .s_axis_tuser           (s_axis_tuser),
    .m_axis_tvalid          (m_axis_tvalid),
    .m_axis_tready          (m_axis_tready),
    .m_axis_tdata           (m_axis_tdata),
    .m_axis_tlast           (m_axis_tlast),
    .drive_revision_wr_en   (drive_revision_wr_en),
    .drive_revision_wr_data (drive_revision_wr_data)
  );

  always #5 clk = ~clk;

  phase_t                   drive_phase = PH_IDLE;
  logic [RetryWidth-1:0]    retries = '0;
  logic                     unreadable_seen = 1'b0;
  logic [RevisionWidth-1:0] revision = '0;

  result_t     pending_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned idle_cycles = 0;
  logic [10:0] actions_seen = '0;

  function automatic void bump_retries();
    if (retries != RETRY_MAX) begin
      retries = retries + 1'b1;
    end
  endfunction

  function automatic result_t next_action(logic func, logic [7:0] status);
    result_t r;
    logic    newer;
    r.act = ACT_POLL;
    r.fin = 1'b0;
    r.dbl = 1'b0;
    newer = revision > NEW_REVISION_FLOOR;
    if (func == FUNC_BEGIN) begin
      retries = '0;
      unreadable_seen = 1'b0;
      drive_phase = PH_POLL;
    end else begin
      case (drive_phase)
        PH_IDLE: begin
          r.fin = 1'b1;
        end
        PH_SPEED: begin
          r.act = ACT_READY;
          r.dbl = status[StDoubleBit];
        end
        PH_EJECT: begin
          r.act = status[StDoorBit] ? ACT_WAIT_POLL : ACT_EJECTED;
        end
        default: begin
          if (!status[StDoorBit]) begin
            r.act = ACT_DOOR_OPEN;
          end else if (!status[StDiscBit]) begin
            if (newer ? !status[StReadyBit] : (retries < NO_DISC_RETRIES)) begin
              r.act = ACT_DELAY_POLL;
              bump_retries();
            end else begin
              r.act = ACT_NO_DISC;
            end
          end else if (!status[StReadyBit]) begin
            if (!newer) begin
              if (retries > NOT_READY_RETRIES) begin
                r.act = ACT_RESET;
              end else begin
                r.act = ACT_DELAY_POLL;
                bump_retries();
              end
            end else if (!unreadable_seen) begin
              unreadable_seen = 1'b1;
              r.act = ACT_DELAY_POLL;
              bump_retries();
            end else begin
              r.act = ACT_EJECT;
              drive_phase = PH_EJECT;
            end
          end else if (!status[StSpinBit]) begin
            r.act = ACT_SPINUP;
            bump_retries();
          end else begin
            r.act = ACT_QUERY;
            drive_phase = PH_SPEED;
          end
        end
      endcase
      if (r.act >= ACT_DOOR_OPEN) begin
        r.fin = 1'b1;
        drive_phase = PH_IDLE;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_status();
    logic [7:0] s;
    s = 8'($urandom);
    s[StDoorBit] = ($urandom_range(0, 15) != 0);
    s[StDiscBit] = ($urandom_range(0, 4) != 0);
    s[StReadyBit] = ($urandom_range(0, 3) != 0);
    s[StSpinBit] = ($urandom_range(0, 2) != 0);
    return s;
  endfunction

  task automatic send_item(logic func, logic [7:0] status);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= status;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    pending_results.push_back(next_action(func, status));
    items_sent++;
  endtask

  task automatic write_revision(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drive_revision_wr_en <= 1'b1;
    drive_revision_wr_data <= value;
    @(posedge clk);
    drive_revision_wr_en <= 1'b0;
    revision = value;
    settings_used++;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch on result %0d: %s", results_seen, msg);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[3:0] <= ACT_READY) begin
        actions_seen[m_axis_tdata[3:0]] = 1'b1;
      end
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result, action %0d, finished %0b",
                                m_axis_tdata[3:0], m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.act) begin
          note_mismatch($sformatf("action expected %0d, actual %0d",
                                  want.act, m_axis_tdata[3:0]));
        end
        if (m_axis_tlast !== want.fin) begin
          note_mismatch($sformatf("finished expected %0b, actual %0b", want.fin, m_axis_tlast));
        end
        if (m_axis_tdata[4] !== want.dbl) begin
          note_mismatch($sformatf("double_speed expected %0b, actual %0b",
                                  want.dbl, m_axis_tdata[4]));
        end
        if (m_axis_tdata[7:5] !== 3'b000) begin
          note_mismatch($sformatf("padding expected 0, actual %0d", m_axis_tdata[7:5]));
        end
      end
    end
  end

  // The receiver alternates between stall patterns and honors long hold requests.
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned mode;
    int unsigned tick;
    logic        ready_next;
    hold_left = 0;
    run_left = 0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (run_left == 0) begin
        run_left = $urandom_range(20, 200);
        mode = $urandom_range(0, 3);
      end
      run_left--;
      if (hold_left == 0 && holds_done != holds_requested) begin
        holds_done++;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (mode)
          0: ready_next = 1'b1;
          1: ready_next = ($urandom_range(0, 9) < 7);
          2: ready_next = (tick % 3) != 0;
          default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no handshake for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    step_row_t   row;
    int unsigned seq_no;
    int unsigned mode;
    int unsigned cap;
    int unsigned rev_pick;
    logic [15:0] rev_value;
    logic [7:0]  status;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedSteps[i];
      if (row.kind == ROW_CFG) begin
        write_revision(row.rev);
      end else begin
        send_item(row.func, row.status);
        if (row.typed) begin
          pending_results[$] = '{act: row.act, fin: row.fin, dbl: row.dbl};
        end
      end
    end

    seq_no = 0;
    while (items_sent < NumDirected - 2 + RandomItems) begin
      seq_no++;
      if (seq_no % 8 == 1) begin
        rev_pick = (settings_used < 6) ? settings_used - 2 : $urandom_range(0, 5);
        case (rev_pick)
          0: rev_value = 16'hFFFF;
          1: rev_value = 16'h0000;
          2: rev_value = NEW_REVISION_FLOOR;
          3: rev_value = NEW_REVISION_FLOOR + 1'b1;
          4: rev_value = 16'($urandom_range(0, NEW_REVISION_FLOOR));
          default: rev_value = 16'($urandom_range(NEW_REVISION_FLOOR + 1, 16'hFFFF));
        endcase
        write_revision(rev_value);
      end

      if (seq_no == LongRunAt) begin
        // An older drive kept not ready runs the retry count up to the hard reset.
        write_revision(16'($urandom_range(0, NEW_REVISION_FLOOR)));
        holds_requested++;
        send_item(FUNC_BEGIN, 8'($urandom));
        while (drive_phase != PH_IDLE) begin
          send_item(FUNC_REPORT, 8'hC0 | (8'($urandom) & 8'h3E));
        end
      end

      if (seq_no == 30) begin
        holds_requested++;
      end

      mode = $urandom_range(0, 19);
      if (mode < 3) begin
        cap = $urandom_range(1, 6);
        repeat (cap) begin
          send_item(($urandom_range(0, 3) == 0) ? FUNC_BEGIN : FUNC_REPORT, 8'($urandom));
        end
      end else begin
        cap = (mode < 6) ? 32 : $urandom_range(1, 40);
        send_item(FUNC_BEGIN, 8'($urandom));
        repeat (cap) begin
          if (drive_phase == PH_IDLE) break;
          status = pick_status();
          if (mode < 6) begin
            status[StDoorBit] = 1'b1;
            status[StDiscBit] = 1'b0;
          end
          if ($urandom_range(0, 39) == 0) begin
            send_item(FUNC_BEGIN, status);
          end else begin
            send_item(FUNC_REPORT, status);
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d items and %0d results under %0d drive revision settings.",
             items_sent, results_seen, settings_used + 1);
    $display("Distinct actions observed: %0d of 11, long receiver holds: %0d.",
             $countones(actions_seen), holds_done);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
